// ----- rtl/core/exact_pattern_stream_matcher_unit_macros.svh -----
// Assertion helpers shared by the matcher RTL.
`ifndef EXACT_PATTERN_STREAM_MATCHER_UNIT_MACROS_SVH
`define EXACT_PATTERN_STREAM_MATCHER_UNIT_MACROS_SVH

`define EPSM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define EPSM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define EPSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/epsm_pkg.sv -----
package epsm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int RUN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LINE_W      = 17;
  localparam int PLEN_W      = 5;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;
  localparam int COUNT_W     = 32;

  localparam logic [7:0]        NEWLINE_BYTE = 8'h0A;
  localparam logic [LINE_W-1:0] LINE_MAX     = 17'd65536;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2,
    REG_MAX_COLUMNS  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               match_found;
    logic [COUNT_W-1:0] total_matches;
    logic [COUNT_W-1:0] matching_lines;
    logic               binary_flag;
  } result_t;

  function automatic logic [7:0] pattern_byte(input logic [DATA_W-1:0] lo,
                                              input logic [DATA_W-1:0] hi,
                                              input logic [IDX_W-1:0]  idx);
    logic [2*DATA_W-1:0] pat;
    pat = {hi, lo};
    return pat[idx*8 +: 8];
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/core/epsm_cell.sv -----
module epsm_cell
  import epsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       active,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  output logic [7:0] byte_out,
  output logic       eq
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign eq       = !active || (byte_in == pat_byte);

endmodule

// ----- rtl/core/epsm_track.sv -----
`include "exact_pattern_stream_matcher_unit_macros.svh"

module epsm_track
  import epsm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              all_eq,
  input  logic [RUN_W-1:0]  len,
  input  logic [LINE_W-1:0] col_limit,
  output result_t           res
);

  logic [RUN_W-1:0]   run_r, run_nxt, run_inc;
  logic [LINE_W-1:0]  line_len_r, line_len_nxt, line_len_inc;
  logic               line_hit_r, line_hit_nxt;
  logic               binary_r, binary_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [COUNT_W-1:0] lines_r, lines_nxt;
  logic               hit;

  assign run_inc      = (run_r < RUN_W'(MAX_PATTERN)) ? run_r + 1'b1 : run_r;
  assign line_len_inc = (line_len_r < LINE_MAX) ? line_len_r + 1'b1 : line_len_r;
  assign hit          = all_eq && (run_inc >= len);

  always_comb begin
    run_nxt      = run_r;
    line_len_nxt = line_len_r;
    line_hit_nxt = line_hit_r;
    binary_nxt   = binary_r;
    total_nxt    = total_r;
    lines_nxt    = lines_r;
    if (step) begin
      run_nxt = hit ? '0 : run_inc;
      if (hit) begin
        total_nxt = sat_inc(total_r);
        if (!binary_r && !line_hit_r) begin
          line_hit_nxt = 1'b1;
          lines_nxt    = sat_inc(lines_r);
        end
      end
      if (!binary_r) begin
        if (data_byte == NEWLINE_BYTE) begin
          line_len_nxt = '0;
          run_nxt      = '0;
          line_hit_nxt = 1'b0;
        end else begin
          line_len_nxt = line_len_inc;
          binary_nxt   = (line_len_inc >= col_limit);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= '0;
      line_len_r <= '0;
      line_hit_r <= 1'b0;
      binary_r   <= 1'b0;
      total_r    <= '0;
      lines_r    <= '0;
    end else begin
      run_r      <= run_nxt;
      line_len_r <= line_len_nxt;
      line_hit_r <= line_hit_nxt;
      binary_r   <= binary_nxt;
      total_r    <= total_nxt;
      lines_r    <= lines_nxt;
    end
  end

  always_comb begin
    res.match_found    = hit;
    res.total_matches  = total_nxt;
    res.matching_lines = lines_nxt;
    res.binary_flag    = binary_nxt;
  end

  `EPSM_ASSERT_NEXT(a_binary_sticky, binary_r, binary_r, "binary mode left")
  `EPSM_ASSERT_ALWAYS(a_run_bound, run_r <= RUN_W'(MAX_PATTERN), "run counter overflow")
  `EPSM_ASSERT_IMPLY(a_line_counted, line_hit_r, lines_r != '0, "matching line not counted")

endmodule

// ----- rtl/core/epsm_outq.sv -----
`include "exact_pattern_stream_matcher_unit_macros.svh"

module epsm_outq
  import epsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic [1:0] count_r, count_nxt;
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;
  logic       pop;

  assign space     = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot0_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_nxt = count_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case (count_r)
      2'd0: begin
        if (push) begin
          slot0_nxt = push_data;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          slot0_nxt = push_data;
        end else if (push) begin
          slot1_nxt = push_data;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          slot0_nxt = slot1_r;
          count_nxt = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  `EPSM_ASSERT_ALWAYS(a_count_bound, count_r != 2'd3, "queue count overflow")
  `EPSM_ASSERT_NEXT(a_pop_drains, pop && !push, count_r == 2'($past(count_r) - 2'd1),
                    "pop without push did not drain")

endmodule

// ----- rtl/core/exact_pattern_stream_matcher_unit.sv -----
// A result transaction is registered in the result queue when its byte is accepted and is offered from the queue head.
// Throughput: 1 byte per cycle; a 2-entry result queue keeps input flowing
// while a result waits, and input stalls only when both entries are full.
// Reset (synchronous, rst_n low): window and counters clear, pattern and length
// registers return to zero and 1, column limit to 65536; no clearing pass.
module exact_pattern_stream_matcher_unit
  import epsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_match_found,
  output logic [COUNT_W-1:0] out_total_matches,
  output logic [COUNT_W-1:0] out_matching_lines,
  output logic               out_binary_flag,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [DATA_W-1:0] pat_lo_r, pat_hi_r;
  logic [PLEN_W-1:0] pat_len_r;
  logic [LINE_W-1:0] max_cols_r;
  logic              wr_en;
  reg_idx_t          reg_sel;
  logic [RUN_W-1:0]  len;
  logic              step;
  logic [MAX_PATTERN-1:0] cell_eq;
  logic [7:0]        chain [MAX_PATTERN+1];
  result_t           res, q_data;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r   <= '0;
      pat_hi_r   <= '0;
      pat_len_r  <= PLEN_W'(1);
      max_cols_r <= LINE_MAX;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PATTERN_LOW:  pat_lo_r   <= pwdata;
        REG_PATTERN_HIGH: pat_hi_r   <= pwdata;
        REG_PATTERN_LEN:  pat_len_r  <= pwdata[PLEN_W-1:0];
        REG_MAX_COLUMNS:  max_cols_r <= pwdata[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PATTERN_LOW:  prdata = pat_lo_r;
      REG_PATTERN_HIGH: prdata = pat_hi_r;
      REG_PATTERN_LEN:  prdata = DATA_W'(pat_len_r);
      REG_MAX_COLUMNS:  prdata = DATA_W'(max_cols_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (pat_len_r == '0) begin
      len = RUN_W'(1);
    end else if (RUN_W'(pat_len_r) > RUN_W'(MAX_PATTERN)) begin
      len = RUN_W'(MAX_PATTERN);
    end else begin
      len = RUN_W'(pat_len_r);
    end
  end

  assign step     = in_valid && in_ready;
  assign chain[0] = in_data_byte;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic             active;
    logic [IDX_W-1:0] pidx;

    assign active = (RUN_W'(k) < len);
    assign pidx   = IDX_W'(len - RUN_W'(k + 1));

    epsm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (step),
      .active   (active),
      .byte_in  (chain[k]),
      .pat_byte (pattern_byte(pat_lo_r, pat_hi_r, pidx)),
      .byte_out (chain[k+1]),
      .eq       (cell_eq[k])
    );
  end

  epsm_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .all_eq    (&cell_eq),
    .len       (len),
    .col_limit (max_cols_r),
    .res       (res)
  );

  epsm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data)
  );

  assign out_match_found    = q_data.match_found;
  assign out_total_matches  = q_data.total_matches;
  assign out_matching_lines = q_data.matching_lines;
  assign out_binary_flag    = q_data.binary_flag;

endmodule

// ----- verif/exact_pattern_stream_matcher_unit_tb.sv -----
module exact_pattern_stream_matcher_unit_tb;
  import epsm_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RESULT_HOLD = 160;
  localparam int MAX_GAP     = 13;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_match_found;
  logic [COUNT_W-1:0] out_total_matches;
  logic [COUNT_W-1:0] out_matching_lines;
  logic               out_binary_flag;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  always #5 clk = ~clk;

  exact_pattern_stream_matcher_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_match_found    (out_match_found),
    .out_total_matches  (out_total_matches),
    .out_matching_lines (out_matching_lines),
    .out_binary_flag    (out_binary_flag),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // matcher model: configuration and scan state
  logic [DATA_W-1:0] model_pat_lo;
  logic [DATA_W-1:0] model_pat_hi;
  logic [PLEN_W-1:0] model_pat_len;
  logic [LINE_W-1:0] model_max_cols;
  logic [7:0]        recent [MAX_PATTERN];
  int unsigned       since_break;
  int unsigned       cur_line_len;
  bit                line_counted;
  bit                in_binary;
  logic [COUNT_W-1:0] hits_total;
  logic [COUNT_W-1:0] line_count;

  result_t    predicted_reports [$];
  logic [7:0] pending_bytes [$];
  result_t    oldest;
  int         bytes_queued = 0;
  int         bytes_taken = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         send_gap_max = 0;
  int         recv_gap_max = 0;
  int         send_wait = 0;
  int         recv_wait = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;

  logic [7:0] gen_pat [MAX_PATTERN];
  int         gen_len = 1;
  int         gen_line_run = 0;

  function automatic void reset_model();
    int i;
    model_pat_lo   = '0;
    model_pat_hi   = '0;
    model_pat_len  = PLEN_W'(1);
    model_max_cols = LINE_MAX;
    for (i = 0; i < MAX_PATTERN; i++) recent[i] = '0;
    since_break  = 0;
    cur_line_len = 0;
    line_counted = 1'b0;
    in_binary    = 1'b0;
    hits_total   = '0;
    line_count   = '0;
  endfunction

  function automatic result_t scan_byte(input logic [7:0] b);
    logic [2*DATA_W-1:0] pat;
    int unsigned plen;
    bit hit;
    int i;
    result_t r;
    pat = {model_pat_hi, model_pat_lo};
    if (model_pat_len == 0) plen = 1;
    else if (model_pat_len > MAX_PATTERN) plen = MAX_PATTERN;
    else plen = model_pat_len;
    for (i = MAX_PATTERN - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = b;
    if (since_break < MAX_PATTERN) since_break++;
    hit = (since_break >= plen);
    for (i = 0; i < plen; i++)
      if (recent[plen-1-i] != pat[i*8 +: 8]) hit = 1'b0;
    if (hit) begin
      since_break = 0;
      if (hits_total != '1) hits_total++;
      if (!in_binary && !line_counted) begin
        line_counted = 1'b1;
        if (line_count != '1) line_count++;
      end
    end
    if (!in_binary) begin
      if (b == NEWLINE_BYTE) begin
        cur_line_len = 0;
        since_break  = 0;
        line_counted = 1'b0;
      end else begin
        if (cur_line_len < LINE_MAX) cur_line_len++;
        if (cur_line_len >= model_max_cols) in_binary = 1'b1;
      end
    end
    r.match_found    = hit;
    r.total_matches  = hits_total;
    r.matching_lines = line_count;
    r.binary_flag    = in_binary;
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_reports.push_back(scan_byte(in_data_byte));
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid     <= 1'b1;
          in_data_byte <= pending_bytes.pop_front();
          send_wait = $urandom_range(0, send_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: match=%0d total=%0d lines=%0d binary=%0d",
                     out_match_found, out_total_matches, out_matching_lines,
                     out_binary_flag);
        end else begin
          oldest = predicted_reports.pop_front();
          if (out_match_found !== oldest.match_found ||
              out_total_matches !== oldest.total_matches ||
              out_matching_lines !== oldest.matching_lines ||
              out_binary_flag !== oldest.binary_flag) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("result %0d mismatch: expected match=%0d total=%0d lines=%0d binary=%0d",
                     results_seen, oldest.match_found, oldest.total_matches,
                     oldest.matching_lines, oldest.binary_flag);
              $display(", got match=%0d total=%0d lines=%0d binary=%0d",
                       out_match_found, out_total_matches, out_matching_lines,
                       out_binary_flag);
            end
          end
        end
        recv_wait = $urandom_range(0, recv_gap_max);
        if (results_seen == 500 || results_seen == 1400) hold_left = RESULT_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:  model_pat_lo = val;
      REG_PATTERN_HIGH: model_pat_hi = val;
      REG_PATTERN_LEN:  model_pat_len = val[PLEN_W-1:0];
      REG_MAX_COLUMNS:  model_max_cols = val[LINE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_taken != bytes_queued || predicted_reports.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
    if (b == NEWLINE_BYTE) gen_line_run = 0;
    else gen_line_run++;
  endtask

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic choose_idling();
    case ($urandom_range(0, 3))
      0: begin send_gap_max = 0;       recv_gap_max = 0;       end
      1: begin send_gap_max = MAX_GAP; recv_gap_max = 0;       end
      2: begin send_gap_max = 0;       recv_gap_max = MAX_GAP; end
      default: begin send_gap_max = MAX_GAP; recv_gap_max = MAX_GAP; end
    endcase
  endtask

  task automatic choose_pattern();
    logic [2*DATA_W-1:0] packed_pat;
    logic [PLEN_W-1:0] len_code;
    int k;
    int pick;
    for (k = 0; k < MAX_PATTERN; k++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) gen_pat[k] = 8'($urandom_range(0, 255));
      else if (pick == 1) gen_pat[k] = NEWLINE_BYTE;
      else gen_pat[k] = 8'h61 + 8'($urandom_range(0, 2));
      packed_pat[k*8 +: 8] = gen_pat[k];
    end
    case ($urandom_range(0, 5))
      0: len_code = '0;
      1: len_code = PLEN_W'(1);
      2: len_code = PLEN_W'(MAX_PATTERN);
      3: len_code = PLEN_W'($urandom_range(MAX_PATTERN + 1, 31));
      default: len_code = PLEN_W'($urandom_range(2, MAX_PATTERN - 1));
    endcase
    if (len_code == 0) gen_len = 1;
    else if (len_code > MAX_PATTERN) gen_len = MAX_PATTERN;
    else gen_len = int'(len_code);
    cfg_write(REG_PATTERN_LOW, packed_pat[DATA_W-1:0]);
    cfg_write(REG_PATTERN_HIGH, packed_pat[2*DATA_W-1:DATA_W]);
    cfg_write(REG_PATTERN_LEN, DATA_W'(len_code));
    case ($urandom_range(0, 2))
      0: cfg_write(REG_MAX_COLUMNS, 64'd65536);
      1: cfg_write(REG_MAX_COLUMNS, 64'd131071);
      default: cfg_write(REG_MAX_COLUMNS, DATA_W'($urandom_range(200, 70000)));
    endcase
  endtask

  // mostly whole or damaged pattern copies, with newlines and noise between
  task automatic feed_mixed_stream(input int count, input bit keep_lines);
    int start;
    int seg;
    int k;
    int cut;
    logic [7:0] b;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      seg = $urandom_range(0, 99);
      if (keep_lines && gen_line_run > 60) begin
        queue_byte(NEWLINE_BYTE);
      end else if (seg < 35) begin
        for (k = 0; k < gen_len; k++) queue_byte(gen_pat[k]);
      end else if (seg < 50) begin
        cut = $urandom_range(0, gen_len - 1);
        for (k = 0; k < gen_len; k++) begin
          b = gen_pat[k];
          if (k == cut) b = b ^ (8'h01 << $urandom_range(0, 7));
          queue_byte(b);
        end
      end else if (seg < 60) begin
        cut = $urandom_range(0, gen_len - 1);
        for (k = 0; k < cut; k++) queue_byte(gen_pat[k]);
      end else if (seg < 75) begin
        queue_byte(NEWLINE_BYTE);
      end else if (seg < 90) begin
        queue_byte(8'h61 + 8'($urandom_range(0, 2)));
      end else begin
        queue_byte(8'($urandom_range(0, 255)));
      end
    end
    if (keep_lines) queue_byte(NEWLINE_BYTE);
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    choose_idling();
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(NEWLINE_BYTE);
    queue_byte(NEWLINE_BYTE);
    queue_byte(8'h7F);
    wait_idle();

    cfg_write(REG_PATTERN_LOW, {56'd0, NEWLINE_BYTE});
    cfg_write(REG_PATTERN_LEN, 64'd0);
    queue_text("\nA\n");
    wait_idle();

    cfg_write(REG_PATTERN_LOW, 64'h6161);
    cfg_write(REG_PATTERN_LEN, 64'd2);
    queue_text("aaaaa\na\naa\n");
    wait_idle();

    cfg_write(REG_PATTERN_LOW, 64'h62);
    cfg_write(REG_PATTERN_LEN, 64'd1);
    cfg_write(REG_MAX_COLUMNS, 64'd2);
    queue_text("b\nc\n\nb\n");
    wait_idle();

    while (bytes_queued < 1550) begin
      choose_pattern();
      choose_idling();
      feed_mixed_stream($urandom_range(40, 150), 1'b1);
      wait_idle();
    end

    choose_pattern();
    case ($urandom_range(0, 2))
      0: cfg_write(REG_MAX_COLUMNS, 64'd0);
      1: cfg_write(REG_MAX_COLUMNS, 64'd1);
      default: cfg_write(REG_MAX_COLUMNS, DATA_W'($urandom_range(2, 40)));
    endcase
    choose_idling();
    feed_mixed_stream(400, 1'b0);
    wait_idle();

    if (mismatches == 0 && predicted_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
